// File: rtl/ddau_pkg.sv
// Shared types, codes and calendar constants of the decimal date arithmetic unit.
package ddau_pkg;

    // Request kinds.
    localparam logic [2:0] K_VALIDATE = 3'd0;
    localparam logic [2:0] K_WEEKDAY  = 3'd1;
    localparam logic [2:0] K_NEXT     = 3'd2;
    localparam logic [2:0] K_PREV     = 3'd3;
    localparam logic [2:0] K_ADD      = 3'd4;
    localparam logic [2:0] K_DIFF     = 3'd5;

    // Day number of 1900-01-01 counted from 0000-03-01, and the last legal day number.
    localparam logic [22:0] DN_EPOCH  = 23'd693901;
    localparam logic [22:0] DN_LAST   = 23'd2958463;
    // Days in one 400-year cycle.
    localparam logic [21:0] ERA_DAYS  = 22'd146097;
    // Bit count of the binary to decimal conversion.
    localparam logic [4:0]  BCD_STEPS = 5'd27;

    typedef struct packed {
        logic [2:0]  kind;
        logic [26:0] date_value;
        logic [26:0] other_date;
        logic [21:0] day_offset;
    } t_req;

    typedef struct packed {
        logic [26:0] result_date;
        logic [2:0]  weekday;
        logic        date_ok;
        logic [21:0] day_span;
        logic        fault;
    } t_res;

    typedef enum logic [3:0] {
        DP_NOP, DP_LOAD, DP_BCD, DP_DECODE, DP_DAYNUM, DP_ARITH,
        DP_ERA, DP_YOE1, DP_YOE2, DP_YOE3, DP_MONTH, DP_PACK
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   sel_b;
    } t_dp_cmd;

    typedef struct packed {
        logic dual;
        logic pack;
        logic era_done;
    } t_dp_stat;

    // First day of year of each month in a March-based year (index 0 is March).
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] v;
        unique case (mp)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // March-based month index of a calendar month.
    function automatic logic [3:0] march_index(input logic [3:0] m);
        logic [3:0] v;
        v = (m > 4'd2) ? m - 4'd3 : m + 4'd9;
        return v;
    endfunction

endpackage

// File: rtl/decimal_date_arithmetic_unit.sv
// Top level of the decimal date arithmetic unit: controller and datapath.
//
// Usage: drive i_req and raise start while busy is low; the request is taken
// at that clock edge and busy rises on the next cycle. The dates are decimal
// numbers YYYYMMDD. The answer on o_res is marked by o_valid, high for
// exactly one cycle, and busy falls right after it.
// Operation: each date is converted to decimal digits one bit a cycle,
// decoded and turned into a day number; a difference converts both
// dates. A result date is rebuilt through an era search that subtracts one
// 400-year cycle per cycle, then five fixed steps. One request is in work
// at a time; the next is taken the cycle after the strobe. The receiver
// cannot stall the result; it must take it in the strobe cycle. Synchronous
// reset returns the unit to idle at once.
module decimal_date_arithmetic_unit
    import ddau_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_res o_res
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    ddau_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    ddau_dp u_dp (
        .i_clk  (i_clk),
        .i_req  (i_req),
        .i_cmd  (cmd),
        .o_stat (stat),
        .o_res  (o_res)
    );

endmodule

// File: rtl/ddau_dp.sv
// Datapath: decimal conversion, day number arithmetic and conversion back to a date.
module ddau_dp
    import ddau_pkg::*;
(
    input  logic     i_clk,
    input  t_req     i_req,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    output t_res     o_res
);

    logic [2:0]  r_kind;
    logic [26:0] r_a, r_b, r_bin;
    logic [21:0] r_off;
    logic [31:0] r_bcd;
    logic [13:0] r_y;
    logic [3:0]  r_m;
    logic [4:0]  r_d;
    logic        r_dec_ok;
    logic [21:0] r_dn_a, r_dn_b;
    logic        r_ok_a, r_ok_b;
    logic        r_fault, r_pack;
    logic [2:0]  r_wd;
    logic [21:0] r_span;
    logic [26:0] r_res;
    logic [21:0] r_z;
    logic [4:0]  r_era;
    logic [35:0] r_p1, r_p2;
    logic [2:0]  r_c36;
    logic        r_c146;
    logic [8:0]  r_yoe, r_doy;

    // Add-3 correction of every decimal digit before each shift.
    logic [31:0] bcd_adj;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            bcd_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                            : r_bcd[4*i +: 4];
        end
    end

    // Field split and validity check of the converted date.
    logic [3:0]  dg [8];
    logic [13:0] dec_y;
    logic [6:0]  dec_m, dec_d, cent;
    logic        c100, leap, in_rng, dec_ok;
    logic [26:0] src;
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            dg[i] = r_bcd[4*i +: 4];
        end
        dec_y  = 14'(dg[7]) * 14'd1000 + 14'(dg[6]) * 14'd100 + 14'(dg[5]) * 14'd10
                 + 14'(dg[4]);
        dec_m  = 7'(dg[3]) * 7'd10 + 7'(dg[2]);
        dec_d  = 7'(dg[1]) * 7'd10 + 7'(dg[0]);
        cent   = 7'(dg[7]) * 7'd10 + 7'(dg[6]);
        c100   = (dg[5] == 4'd0) && (dg[4] == 4'd0);
        leap   = ((dec_y[1:0] == 2'd0) && !c100) || (c100 && (cent[1:0] == 2'd0));
        src    = i_cmd.sel_b ? r_b : r_a;
        in_rng = (src >= 27'd10000000) && (src <= 27'd99999999);
        dec_ok = in_rng && (dec_y >= 14'd1900) && (dec_y <= 14'd9999)
                 && (dec_m >= 7'd1) && (dec_m <= 7'd12) && (dec_d >= 7'd1) && (dec_d <= 7'd31)
                 && !((dec_m == 7'd2) && (dec_d > 7'd29))
                 && !((dec_m == 7'd2) && (dec_d == 7'd29) && !leap)
                 && !((dec_d == 7'd31) && ((dec_m == 7'd4) || (dec_m == 7'd6)
                      || (dec_m == 7'd9) || (dec_m == 7'd11)));
    end

    // Day number of the decoded date, years counted from March.
    logic [13:0] yb;
    logic [26:0] q_prod;
    logic [6:0]  q100;
    logic [22:0] abs_dn;
    logic [21:0] dn_calc;
    always_comb begin
        yb      = r_y - 14'(r_m <= 4'd2);
        q_prod  = 27'(yb) * 27'd5243;
        q100    = 7'(q_prod >> 19);
        abs_dn  = 23'(yb) * 23'd365 + 23'(yb[13:2]) - 23'(q100) + 23'(q100[6:2])
                  + 23'(month_start(march_index(r_m))) + 23'(r_d) - 23'd1;
        dn_calc = 22'(abs_dn - DN_EPOCH);
    end

    // Operation select, range checks and weekday.
    logic [22:0] dn_sum, dn_target;
    logic [23:0] wx;
    logic [5:0]  s1;
    logic [3:0]  s2;
    logic [2:0]  wd_calc;
    logic        n_fault, n_pack;
    logic [2:0]  n_wd;
    logic [21:0] n_span;
    always_comb begin
        dn_sum = 23'(r_dn_a) + ((r_kind == K_NEXT) ? 23'd1 : 23'(r_off));
        wx     = 24'(r_dn_a) + 24'd1;
        s1     = '0;
        for (int i = 0; i < 8; i++) begin
            s1 = s1 + 6'(wx[3*i +: 3]);
        end
        s2      = 4'(s1[5:3]) + 4'(s1[2:0]);
        wd_calc = (s2 >= 4'd14) ? 3'd0 : (s2 >= 4'd7) ? 3'(s2 - 4'd7) : 3'(s2);
        n_fault   = 1'b0;
        n_pack    = 1'b0;
        n_wd      = 3'd0;
        n_span    = 22'd0;
        dn_target = dn_sum;
        unique case (r_kind)
            K_VALIDATE: n_fault = 1'b0;
            K_WEEKDAY: begin
                if (r_ok_a) n_wd = wd_calc;
                else        n_fault = 1'b1;
            end
            K_NEXT, K_ADD: begin
                if (!r_ok_a || (dn_sum > DN_LAST)) n_fault = 1'b1;
                else                               n_pack = 1'b1;
            end
            K_PREV: begin
                dn_target = 23'(r_dn_a) - 23'd1;
                if (!r_ok_a || (r_dn_a == 22'd0)) n_fault = 1'b1;
                else                              n_pack = 1'b1;
            end
            K_DIFF: begin
                if (!r_ok_a || !r_ok_b)   n_fault = 1'b1;
                else if (r_dn_a > r_dn_b) n_span = r_dn_a - r_dn_b;
                else                      n_span = r_dn_b - r_dn_a;
            end
            default: n_fault = 1'b1;
        endcase
    end

    // Year of era from the day of era.
    logic [17:0] doe, yt;
    logic [8:0]  yoe;
    logic [1:0]  yq100;
    logic [17:0] doy_full;
    always_comb begin
        doe      = r_z[17:0];
        yt       = doe - 18'(r_p1 >> 28) + 18'(r_c36) - 18'(r_c146);
        yoe      = 9'(r_p2 >> 26);
        yq100    = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2
                 : (yoe >= 9'd100) ? 2'd1 : 2'd0;
        doy_full = doe - (18'(yoe) * 18'd365 + 18'(yoe[8:2]) - 18'(yq100));
    end

    // Month and day from the day of year.
    logic [3:0]  mp;
    logic [3:0]  mm;
    logic [4:0]  dd;
    logic [13:0] yy;
    always_comb begin
        mp = 4'd0;
        for (int i = 1; i < 12; i++) begin
            mp = mp + 4'(r_doy >= month_start(4'(i)));
        end
        dd = 5'(r_doy - month_start(mp) + 9'd1);
        mm = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
        yy = 14'(r_yoe) + 14'(r_era) * 14'd400 + 14'(mm <= 4'd2);
    end

    // Datapath registers, advanced by the controller's command.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_NOP: ;
            DP_LOAD: begin
                r_kind <= i_req.kind;
                r_a    <= i_req.date_value;
                r_b    <= i_req.other_date;
                r_off  <= i_req.day_offset;
                r_bin  <= i_req.date_value;
                r_bcd  <= '0;
            end
            DP_BCD: begin
                r_bin <= {r_bin[25:0], 1'b0};
                r_bcd <= {bcd_adj[30:0], r_bin[26]};
            end
            DP_DECODE: begin
                r_y      <= dec_y;
                r_m      <= dec_m[3:0];
                r_d      <= dec_d[4:0];
                r_dec_ok <= dec_ok;
            end
            DP_DAYNUM: begin
                if (i_cmd.sel_b) begin
                    r_dn_b <= dn_calc;
                    r_ok_b <= r_dec_ok;
                end else begin
                    r_dn_a <= dn_calc;
                    r_ok_a <= r_dec_ok;
                end
                r_bin <= r_b;
                r_bcd <= '0;
            end
            DP_ARITH: begin
                r_fault <= n_fault;
                r_pack  <= n_pack;
                r_wd    <= n_wd;
                r_span  <= n_span;
                r_res   <= '0;
                r_z     <= 22'(dn_target + DN_EPOCH);
                r_era   <= '0;
            end
            DP_ERA: begin
                if (r_z >= ERA_DAYS) begin
                    r_z   <= r_z - ERA_DAYS;
                    r_era <= r_era + 5'd1;
                end
            end
            DP_YOE1: begin
                r_p1   <= 36'(doe) * 36'd183861;
                r_c36  <= 3'(doe >= 18'd36524) + 3'(doe >= 18'd73048)
                        + 3'(doe >= 18'd109572) + 3'(doe >= 18'd146096);
                r_c146 <= (doe == 18'd146096);
            end
            DP_YOE2: r_p2 <= 36'(yt) * 36'd183860;
            DP_YOE3: begin
                r_yoe <= yoe;
                r_doy <= doy_full[8:0];
            end
            DP_MONTH: begin
                r_y <= yy;
                r_m <= mm;
                r_d <= dd;
            end
            DP_PACK: r_res <= 27'(r_y) * 27'd10000 + 27'(r_m) * 27'd100 + 27'(r_d);
            default: ;
        endcase
    end

    assign o_stat.dual     = (r_kind == K_DIFF);
    assign o_stat.pack     = r_pack;
    assign o_stat.era_done = (r_z < ERA_DAYS);

    assign o_res.result_date = r_res;
    assign o_res.weekday     = r_wd;
    assign o_res.date_ok     = r_ok_a;
    assign o_res.day_span    = r_span;
    assign o_res.fault       = r_fault;

endmodule

// File: rtl/ddau_ctrl.sv
// Controller: sequences the datapath through conversion, arithmetic and packing.
module ddau_ctrl
    import ddau_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_busy,
    output logic     o_valid
);

    typedef enum logic [3:0] {
        S_IDLE, S_BCD_A, S_DEC_A, S_DN_A, S_BCD_B, S_DEC_B, S_DN_B, S_ARITH,
        S_ERA, S_YOE1, S_YOE2, S_YOE3, S_MONTH, S_PACK, S_DONE
    } t_state;

    t_state     r_state;
    logic [4:0] r_cnt;

    // State register and conversion step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (i_start) r_state <= S_BCD_A;
                end
                S_BCD_A, S_BCD_B: begin
                    if (r_cnt == BCD_STEPS - 5'd1) begin
                        r_cnt   <= '0;
                        r_state <= (r_state == S_BCD_A) ? S_DEC_A : S_DEC_B;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DEC_A: r_state <= S_DN_A;
                S_DN_A:  r_state <= i_stat.dual ? S_BCD_B : S_ARITH;
                S_DEC_B: r_state <= S_DN_B;
                S_DN_B:  r_state <= S_ARITH;
                S_ARITH: r_state <= S_ERA;
                S_ERA: begin
                    if (!i_stat.pack)         r_state <= S_DONE;
                    else if (i_stat.era_done) r_state <= S_YOE1;
                end
                S_YOE1:  r_state <= S_YOE2;
                S_YOE2:  r_state <= S_YOE3;
                S_YOE3:  r_state <= S_MONTH;
                S_MONTH: r_state <= S_PACK;
                S_PACK:  r_state <= S_DONE;
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath command for each state.
    always_comb begin
        o_cmd.sel_b = 1'b0;
        unique case (r_state)
            S_IDLE:           o_cmd.op = i_start ? DP_LOAD : DP_NOP;
            S_BCD_A, S_BCD_B: o_cmd.op = DP_BCD;
            S_DEC_A:          o_cmd.op = DP_DECODE;
            S_DN_A:           o_cmd.op = DP_DAYNUM;
            S_DEC_B: begin
                o_cmd.op    = DP_DECODE;
                o_cmd.sel_b = 1'b1;
            end
            S_DN_B: begin
                o_cmd.op    = DP_DAYNUM;
                o_cmd.sel_b = 1'b1;
            end
            S_ARITH:          o_cmd.op = DP_ARITH;
            S_ERA:            o_cmd.op = DP_ERA;
            S_YOE1:           o_cmd.op = DP_YOE1;
            S_YOE2:           o_cmd.op = DP_YOE2;
            S_YOE3:           o_cmd.op = DP_YOE3;
            S_MONTH:          o_cmd.op = DP_MONTH;
            S_PACK:           o_cmd.op = DP_PACK;
            default:          o_cmd.op = DP_NOP;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    // The result strobe lasts one cycle and the unit returns to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result strobe not followed by idle");

    // A request taken in idle starts the first conversion.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> (r_state == S_BCD_A))
        else $error("request not started");

    // The conversion counter stays within the bit count.
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < BCD_STEPS)
        else $error("conversion counter overrun");

    // A single-date request goes from its day number straight to the arithmetic step.
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DN_A && !i_stat.dual) |=> (r_state == S_ARITH))
        else $error("single-date request took the second conversion");

endmodule

// File: tb/tb_decimal_date_arithmetic_unit.sv
// Testbench of the decimal date arithmetic unit: random and directed date requests checked against a calendar predictor.
`timescale 1ns / 1ps

module tb_decimal_date_arithmetic_unit;
    import ddau_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] K_BAD6 = 3'd6;
    localparam logic [2:0] K_BAD7 = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_valid;
    t_res o_res;

    t_req pending_reqs[$];
    t_res expected_answers[$];
    int   error_count;
    int   cycle_count;
    bit   stimulus_done;
    int   gap_left;

    decimal_date_arithmetic_unit u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_res  (o_res)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit is_leap(input longint unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Splits a decimal date and checks that the calendar day exists.
    function automatic bit date_valid(input longint unsigned v, output longint unsigned y,
                                      output longint unsigned m, output longint unsigned d);
        y = v / 10000;
        m = (v / 100) % 100;
        d = v % 100;
        if (v < 10000000 || v > 99999999) return 1'b0;
        if (y < 1900 || y > 9999 || m < 1 || m > 12 || d < 1 || d > 31) return 1'b0;
        if (m == 2 && d > 29) return 1'b0;
        if (m == 2 && d == 29 && !is_leap(y)) return 1'b0;
        if (d == 31 && (m == 4 || m == 6 || m == 9 || m == 11)) return 1'b0;
        return 1'b1;
    endfunction

    // Days since 0000-03-01 in the proleptic calendar.
    function automatic longint unsigned civil_days(input longint unsigned y,
                                                   input longint unsigned m,
                                                   input longint unsigned d);
        longint unsigned era, yoe, doy, mp;
        if (m <= 2) y = y - 1;
        era = y / 400;
        yoe = y - era * 400;
        mp = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    endfunction

    function automatic longint unsigned epoch_days(input longint unsigned y,
                                                   input longint unsigned m,
                                                   input longint unsigned d);
        return civil_days(y, m, d) - civil_days(1900, 1, 1);
    endfunction

    // Rebuilds a decimal date from a day count since 1900-01-01.
    function automatic longint unsigned date_of_days(input longint unsigned dn);
        longint unsigned z, era, doe, yoe, y, doy, mp, d, m;
        z = dn + civil_days(1900, 1, 1);
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        y = yoe + era * 400;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        d = doy - (153 * mp + 2) / 5 + 1;
        m = (mp < 10) ? mp + 3 : mp - 9;
        if (m <= 2) y = y + 1;
        return y * 10000 + m * 100 + d;
    endfunction

    // Expected answer of one date request.
    function automatic t_res date_answer(input t_req r);
        t_res a;
        longint unsigned y, m, d, y2, m2, d2, dn, dn2, last;
        bit ok, ok2;
        a = '0;
        ok = date_valid(r.date_value, y, m, d);
        ok2 = date_valid(r.other_date, y2, m2, d2);
        dn = ok ? epoch_days(y, m, d) : 0;
        last = epoch_days(9999, 12, 31);
        a.date_ok = ok;
        case (r.kind)
            K_VALIDATE: ;
            K_WEEKDAY: begin
                if (ok) a.weekday = 3'((dn + 1) % 7);
                else a.fault = 1'b1;
            end
            K_NEXT, K_PREV, K_ADD: begin
                if (!ok) begin
                    a.fault = 1'b1;
                end else if (r.kind == K_PREV) begin
                    if (dn == 0) a.fault = 1'b1;
                    else a.result_date = 27'(date_of_days(dn - 1));
                end else begin
                    dn = dn + ((r.kind == K_NEXT) ? 1 : r.day_offset);
                    if (dn > last) a.fault = 1'b1;
                    else a.result_date = 27'(date_of_days(dn));
                end
            end
            K_DIFF: begin
                if (!ok || !ok2) begin
                    a.fault = 1'b1;
                end else begin
                    dn2 = epoch_days(y2, m2, d2);
                    a.day_span = 22'((dn > dn2) ? dn - dn2 : dn2 - dn);
                end
            end
            default: a.fault = 1'b1;
        endcase
        return a;
    endfunction

    // A random valid date, mostly spread over all years.
    function automatic logic [26:0] any_valid_date();
        longint unsigned y, m, d, lim;
        y = $urandom_range(9999, 1900);
        if ($urandom_range(3) == 0) y = $urandom_range(1, 0) ? $urandom_range(1905, 1900)
                                                            : $urandom_range(9999, 9994);
        m = $urandom_range(12, 1);
        lim = (m == 2) ? (is_leap(y) ? 29 : 28)
                       : ((m == 4 || m == 6 || m == 9 || m == 11) ? 30 : 31);
        d = ($urandom_range(3) == 0) ? lim : $urandom_range(lim, 1);
        return 27'(y * 10000 + m * 100 + d);
    endfunction

    function automatic logic [26:0] any_date();
        case ($urandom_range(9))
            0: return 27'($urandom);
            1: return 27'($urandom_range(99999999, 0));
            2: return 27'({$urandom_range(9999, 1900)} * 10000 + $urandom_range(99, 0) * 100
                          + $urandom_range(99, 0));
            default: return any_valid_date();
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] k, input logic [26:0] a, input logic [26:0] b,
                             input logic [21:0] off);
        t_req r;
        r.kind = k;
        r.date_value = a;
        r.other_date = b;
        r.day_offset = off;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("tb: mismatch %s got %0d expected %0d", what, got, want);
        error_count++;
    endtask

    // Fill the request queue: directed corner cases first, then random requests.
    initial begin
        logic [2:0] k;
        logic [26:0] a;
        logic [21:0] off;
        error_count = 0;
        stimulus_done = 1'b0;
        queue_req(K_VALIDATE, 27'd19000101, 27'd0, 22'd0);
        queue_req(K_VALIDATE, 27'd99991231, 27'd0, 22'd0);
        queue_req(K_VALIDATE, 27'd20000229, 27'd0, 22'd0);
        queue_req(K_VALIDATE, 27'd19000229, 27'd0, 22'd0);
        queue_req(K_VALIDATE, 27'd20230431, 27'd0, 22'd0);
        queue_req(K_VALIDATE, 27'h7FFFFFF, 27'h7FFFFFF, 22'h3FFFFF);
        queue_req(K_VALIDATE, 27'd0, 27'd0, 22'd0);
        queue_req(K_WEEKDAY, 27'd19000101, 27'd0, 22'd0);
        queue_req(K_WEEKDAY, 27'd99991231, 27'd0, 22'd0);
        queue_req(K_WEEKDAY, 27'd18991231, 27'd0, 22'd0);
        queue_req(K_NEXT, 27'd99991231, 27'd0, 22'd0);
        queue_req(K_NEXT, 27'd20000228, 27'd0, 22'd0);
        queue_req(K_NEXT, 27'd19991231, 27'd0, 22'd0);
        queue_req(K_PREV, 27'd19000101, 27'd0, 22'd0);
        queue_req(K_PREV, 27'd20000301, 27'd0, 22'd0);
        queue_req(K_ADD, 27'd19000101, 27'd0, 22'd2958463);
        queue_req(K_ADD, 27'd19000102, 27'd0, 22'd2958463);
        queue_req(K_ADD, 27'd19000101, 27'd0, 22'h3FFFFF);
        queue_req(K_ADD, 27'd19000230, 27'd0, 22'd0);
        queue_req(K_DIFF, 27'd19000101, 27'd99991231, 22'd0);
        queue_req(K_DIFF, 27'd99991231, 27'd19000101, 22'd0);
        queue_req(K_DIFF, 27'd20000230, 27'd20000230, 22'd0);
        queue_req(K_DIFF, 27'd20240101, 27'd20241301, 22'd0);
        queue_req(K_BAD6, 27'd20240101, 27'd0, 22'd0);
        queue_req(K_BAD7, 27'd12345, 27'd0, 22'd0);
        for (int i = 0; i < 800; i++) begin
            k = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5, 0));
            a = any_date();
            case ($urandom_range(4))
                0: off = 22'($urandom);
                1: off = 22'($urandom_range(2958463, 0));
                2: off = 22'($urandom_range(40, 0));
                default: off = 22'($urandom_range(400000, 0));
            endcase
            queue_req(k, a, ($urandom_range(7) == 0) ? 27'($urandom) : any_date(), off);
        end
        stimulus_done = 1'b1;
    end

    // Reset, then watch the end of the run.
    initial begin
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stimulus_done && pending_reqs.size() == 0 && expected_answers.size() == 0
              && !start);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_answers.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial cycle_count = 0;

    // Driver: presents requests on the falling edge with random gaps.
    initial begin
        start = 1'b0;
        i_req = '0;
        gap_left = 0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                // Handled by the accepting edge below; nothing to do here.
            end
            if (start) begin
                start <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (pending_reqs.size() == 0) begin
                // Idle.
            end else if (pending_reqs.size() == 700 && expected_answers.size() != 0) begin
                // Hold off until every expected answer has come.
            end else if (!busy) begin
                i_req <= pending_reqs.pop_front();
                start <= 1'b1;
                case ($urandom_range(9))
                    0, 1, 2, 3: gap_left <= 0;
                    9: gap_left <= $urandom_range(60, 10);
                    default: gap_left <= $urandom_range(4, 1);
                endcase
            end
        end
    end

    // Record each accepted request and its predicted answer.
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) begin
            expected_answers.push_back(date_answer(i_req));
        end
    end

    // Monitor: compare each strobed answer with the oldest expectation.
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected answer, result_date", o_res.result_date, 0);
            end else begin
                want = expected_answers.pop_front();
                if (o_res.result_date !== want.result_date)
                    report_mismatch("result_date", o_res.result_date, want.result_date);
                if (o_res.weekday !== want.weekday)
                    report_mismatch("weekday", o_res.weekday, want.weekday);
                if (o_res.date_ok !== want.date_ok)
                    report_mismatch("date_ok", o_res.date_ok, want.date_ok);
                if (o_res.day_span !== want.day_span)
                    report_mismatch("day_span", o_res.day_span, want.day_span);
                if (o_res.fault !== want.fault)
                    report_mismatch("fault", o_res.fault, want.fault);
            end
        end
    end

endmodule
